// ===== hw/rtl/hvn_pkg.sv =====
// shared types, widths and constants for the heightmap vertex normal block
package hvn_pkg;

  localparam int MAX_GRID_DEF = 256;

  localparam int PIX_W    = 8;
  localparam int COORD_W  = 8;
  localparam int GRID_W   = 9;
  localparam int MH_W     = 16;
  localparam int HEIGHT_W = 17;
  localparam int NRM_W    = 16;
  localparam int NRMY_W   = 15;

  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(256);
  localparam logic [MH_W-1:0]   MH_RESET   = MH_W'(2560);

  // |pixel difference| * max height
  localparam int MAG_W  = 24;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int FRAC_SHIFT = 12;
  localparam int ROOT_W = (SUM_W + FRAC_SHIFT) / 2;
  localparam int DIV_SHIFT = 22;
  localparam int NUM_W  = MAG_W + DIV_SHIFT + 1;
  localparam int DEN_W  = ROOT_W + 1;
  localparam int QUO_W  = 17;

  // up vector in the same units as the differences
  localparam logic [MAG_W-1:0] C_VEC = MAG_W'(65280);
  localparam logic [SUM_W-1:0] C_SQ  = SUM_W'(64'd4261478400);

  // height rounding: floor((n + 127) / 255) through a reciprocal
  localparam int Y_W         = 25;
  localparam int RECIP_W     = 26;
  localparam int HP_W        = Y_W + RECIP_W;
  localparam int RECIP_SHIFT = 33;
  localparam logic [RECIP_W-1:0] RECIP_255 = RECIP_W'(33686019);
  localparam logic [Y_W-1:0]     HROUND    = Y_W'(127);

  localparam logic [QUO_W-1:0] SAT_POS = QUO_W'(32767);
  localparam logic [QUO_W-1:0] SAT_NEG = QUO_W'(32768);

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_GRID_SIZE  = 1'b0,
    REG_MAX_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam int NUM_TAPS = 5;

  typedef enum logic [2:0] {
    TAP_C = 3'd0,
    TAP_L = 3'd1,
    TAP_R = 3'd2,
    TAP_D = 3'd3,
    TAP_U = 3'd4
  } tap_t;

endpackage

// ===== hw/rtl/hvn_ram.sv =====
// generic single write port ram with registered read
module hvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/hvn_addr.sv =====
// neighbour clamping and linear address generation for the five taps
module hvn_addr #(
  parameter int MAX_GRID = hvn_pkg::MAX_GRID_DEF,
  parameter int AW       = 16
) (
  input  logic [hvn_pkg::GRID_W-1:0]  grid_size,
  input  logic [hvn_pkg::COORD_W-1:0] col,
  input  logic [hvn_pkg::COORD_W-1:0] row,
  output logic [AW-1:0]               addr [hvn_pkg::NUM_TAPS],
  output logic                        wr_ok
);

  localparam int GW = hvn_pkg::GRID_W;
  localparam int LW = 2 * GW + 1;

  logic [GW-1:0] g, gm1;
  logic [GW-1:0] col_w, row_w;
  logic [GW-1:0] cc, cl, cr, rc, rl, rr;

  function automatic logic [GW-1:0] clamp_hi(input logic [GW-1:0] v, input logic [GW-1:0] hi);
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [LW-1:0] lin(input logic [GW-1:0] r, input logic [GW-1:0] c,
                                        input logic [GW-1:0] gs);
    logic [LW-1:0] rw, cw, gw;
    rw = LW'(r);
    cw = LW'(c);
    gw = LW'(gs);
    return rw * gw + cw;
  endfunction

  always_comb begin
    if (grid_size < GW'(2)) begin
      g = GW'(2);
    end else if (32'(grid_size) > MAX_GRID) begin
      g = GW'(MAX_GRID);
    end else begin
      g = grid_size;
    end
    gm1   = g - GW'(1);
    col_w = GW'(col);
    row_w = GW'(row);
    cc = clamp_hi(col_w, gm1);
    rc = clamp_hi(row_w, gm1);
    cl = clamp_hi((col == '0) ? '0 : col_w - GW'(1), gm1);
    rl = clamp_hi((row == '0) ? '0 : row_w - GW'(1), gm1);
    cr = clamp_hi(col_w + GW'(1), gm1);
    rr = clamp_hi(row_w + GW'(1), gm1);
    addr[hvn_pkg::TAP_C] = AW'(lin(rc, cc, g));
    addr[hvn_pkg::TAP_L] = AW'(lin(rc, cl, g));
    addr[hvn_pkg::TAP_R] = AW'(lin(rc, cr, g));
    addr[hvn_pkg::TAP_D] = AW'(lin(rl, cc, g));
    addr[hvn_pkg::TAP_U] = AW'(lin(rr, cc, g));
    wr_ok = (col_w < g) && (row_w < g);
  end

endmodule

// ===== hw/rtl/hvn_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module hvn_isqrt #(
  parameter int ROOT_W = hvn_pkg::ROOT_W,
  parameter int TAG_W  = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [2*ROOT_W-1:0] in_val,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_vld,
  output logic [ROOT_W-1:0]   out_root,
  output logic [TAG_W-1:0]    out_tag
);

  localparam int STAGES = ROOT_W;
  localparam int IN_W   = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int T_W    = REM_W + 2;

  logic [REM_W-1:0]  rem_q  [STAGES];
  logic [ROOT_W-1:0] root_q [STAGES];
  logic [IN_W-1:0]   n_q    [STAGES];
  logic [TAG_W-1:0]  tag_q  [STAGES];
  logic [STAGES-1:0] vld_q;

  logic [REM_W-1:0]  rem_in  [STAGES];
  logic [ROOT_W-1:0] root_in [STAGES];
  logic [IN_W-1:0]   n_in    [STAGES];
  logic [TAG_W-1:0]  tag_in  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [T_W-1:0]    t, trial;
    logic [REM_W-1:0]  rem_n;
    logic [ROOT_W-1:0] root_n;

    if (s == 0) begin : g_first
      assign rem_in[s]  = '0;
      assign root_in[s] = '0;
      assign n_in[s]    = in_val;
      assign tag_in[s]  = in_tag;
    end else begin : g_next
      assign rem_in[s]  = rem_q[s-1];
      assign root_in[s] = root_q[s-1];
      assign n_in[s]    = n_q[s-1];
      assign tag_in[s]  = tag_q[s-1];
    end

    always_comb begin
      t     = {rem_in[s], n_in[s][IN_W-1 -: 2]};
      trial = T_W'({root_in[s], 2'b01});
      if (t >= trial) begin
        rem_n  = REM_W'(t - trial);
        root_n = {root_in[s][ROOT_W-2:0], 1'b1};
      end else begin
        rem_n  = REM_W'(t);
        root_n = {root_in[s][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= rem_n;
        root_q[s] <= root_n;
        n_q[s]    <= {n_in[s][IN_W-3:0], 2'b00};
        tag_q[s]  <= tag_in[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[STAGES-2:0], in_vld};
    end
  end

  assign out_vld  = vld_q[STAGES-1];
  assign out_root = root_q[STAGES-1];
  assign out_tag  = tag_q[STAGES-1];

endmodule

// ===== hw/rtl/hvn_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module hvn_div #(
  parameter int NUM_W = hvn_pkg::NUM_W,
  parameter int DEN_W = hvn_pkg::DEN_W,
  parameter int QUO_W = hvn_pkg::QUO_W,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [QUO_W-1:0] quo,
  output logic [TAG_W-1:0] out_tag
);

  localparam int STAGES = QUO_W;
  localparam int R_W    = DEN_W + 1;
  localparam int T_W    = DEN_W + 2;

  logic [R_W-1:0]    r_q   [STAGES];
  logic [QUO_W-1:0]  lo_q  [STAGES];
  logic [QUO_W-1:0]  q_q   [STAGES];
  logic [DEN_W-1:0]  d_q   [STAGES];
  logic [TAG_W-1:0]  tag_q [STAGES];
  logic [STAGES-1:0] vld_q;

  logic [R_W-1:0]   r_in   [STAGES];
  logic [QUO_W-1:0] lo_in  [STAGES];
  logic [QUO_W-1:0] q_in   [STAGES];
  logic [DEN_W-1:0] d_in   [STAGES];
  logic [TAG_W-1:0] tag_in [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [T_W-1:0] t;
    logic [R_W-1:0] r_n;
    logic           qb;

    if (s == 0) begin : g_first
      // quotient fits QUO_W bits, so the upper part is already below the divisor
      assign r_in[s]   = R_W'(num[NUM_W-1:QUO_W]);
      assign lo_in[s]  = num[QUO_W-1:0];
      assign q_in[s]   = '0;
      assign d_in[s]   = den;
      assign tag_in[s] = in_tag;
    end else begin : g_next
      assign r_in[s]   = r_q[s-1];
      assign lo_in[s]  = lo_q[s-1];
      assign q_in[s]   = q_q[s-1];
      assign d_in[s]   = d_q[s-1];
      assign tag_in[s] = tag_q[s-1];
    end

    always_comb begin
      t = {r_in[s], lo_in[s][QUO_W-1]};
      if (t >= T_W'(d_in[s])) begin
        r_n = R_W'(t - T_W'(d_in[s]));
        qb  = 1'b1;
      end else begin
        r_n = R_W'(t);
        qb  = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[s]   <= r_n;
        lo_q[s]  <= {lo_in[s][QUO_W-2:0], 1'b0};
        q_q[s]   <= {q_in[s][QUO_W-2:0], qb};
        d_q[s]   <= d_in[s];
        tag_q[s] <= tag_in[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[STAGES-2:0], in_vld};
    end
  end

  assign out_vld = vld_q[STAGES-1];
  assign quo     = q_q[STAGES-1];
  assign out_tag = tag_q[STAGES-1];

endmodule

// ===== hw/rtl/heightmap_vertex_normal.sv =====
// top level: heightmap store, vertex height and central difference normal
//
//   channel  | handshake               | beat
//   ---------+-------------------------+------------------------------------------
//   cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//   in       | in_valid / in_stall     | op, col, row, pixel
//   out      | out_valid / out_stall   | vertex_height, normal_x, normal_y, normal_z
//
// one beat per cycle in while in_stall is low; a query passes through the ram read, three
// arithmetic stages, 31 square root stages, 17 divider stages and the output register.
// five replicated heightmap rams, one read port each, give the five taps of a query
// in the same cycle; writes go to all replicas at once.
// reset is synchronous, clears the pipeline valids and sets the config registers to defaults.
// the pipe keeps moving while a result waits on out_stall; in_stall rises only when
// the output register and the last pipeline stage are both full.
module heightmap_vertex_normal #(
  parameter int MAX_GRID = hvn_pkg::MAX_GRID_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  hvn_pkg::cfg_reg_t                   cfg_index,
  input  logic [hvn_pkg::MH_W-1:0]            cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  hvn_pkg::op_t                        op,
  input  logic [hvn_pkg::COORD_W-1:0]         col,
  input  logic [hvn_pkg::COORD_W-1:0]         row,
  input  logic [hvn_pkg::PIX_W-1:0]           pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hvn_pkg::HEIGHT_W-1:0] vertex_height,
  output logic signed [hvn_pkg::NRM_W-1:0]    normal_x,
  output logic [hvn_pkg::NRMY_W-1:0]          normal_y,
  output logic signed [hvn_pkg::NRM_W-1:0]    normal_z
);

  localparam int Depth = MAX_GRID * MAX_GRID;
  localparam int AW    = $clog2(Depth);
  localparam int MAG_W = hvn_pkg::MAG_W;
  localparam int HW    = hvn_pkg::HEIGHT_W;
  localparam int QW    = hvn_pkg::QUO_W;
  localparam int RW    = hvn_pkg::ROOT_W;
  localparam int SQ_TAG_W = 2 * (MAG_W + 1) + HW;

  logic [hvn_pkg::GRID_W-1:0] grid_size;
  logic [hvn_pkg::MH_W-1:0]   max_height_q8;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size     <= hvn_pkg::GRID_RESET;
      max_height_q8 <= hvn_pkg::MH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hvn_pkg::REG_GRID_SIZE:  grid_size     <= cfg_data[hvn_pkg::GRID_W-1:0];
        hvn_pkg::REG_MAX_HEIGHT: max_height_q8 <= cfg_data;
        default:                 grid_size     <= grid_size;
      endcase
    end
  end

  logic en, acc, v_last, out_block;

  assign out_block = out_valid && out_stall;
  assign en        = !(v_last && out_block);
  assign in_stall  = !en;
  assign acc       = in_valid && en;

  // address generation and heightmap replicas
  logic [AW-1:0]                taddr [hvn_pkg::NUM_TAPS];
  logic [hvn_pkg::PIX_W-1:0]    pix   [hvn_pkg::NUM_TAPS];
  logic                         wr_ok, we;

  hvn_addr #(
    .MAX_GRID (MAX_GRID),
    .AW       (AW)
  ) u_addr (
    .grid_size (grid_size),
    .col       (col),
    .row       (row),
    .addr      (taddr),
    .wr_ok     (wr_ok)
  );

  assign we = acc && (op == hvn_pkg::OP_WRITE) && wr_ok;

  for (genvar t = 0; t < hvn_pkg::NUM_TAPS; t++) begin : g_ram
    hvn_ram #(
      .WIDTH (hvn_pkg::PIX_W),
      .DEPTH (Depth)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (taddr[hvn_pkg::TAP_C]),
      .wdata (pixel),
      .re    (en),
      .raddr (taddr[t]),
      .rdata (pix[t])
    );
  end

  // stage valids
  logic v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= acc && (op == hvn_pkg::OP_QUERY);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 2: differences and centre height magnitude scaled by max height
  logic [hvn_pkg::PIX_W-1:0] pl, pr, pd, pu, pc;
  logic [hvn_pkg::PIX_W-1:0] dx_mag, dz_mag, hc_mag;
  logic                      dx_neg, dz_neg;
  logic [MAG_W-1:0]          amag2, bmag2, nmag2;
  logic                      sa2, sb2, hneg2;

  always_comb begin
    pl = pix[hvn_pkg::TAP_L];
    pr = pix[hvn_pkg::TAP_R];
    pd = pix[hvn_pkg::TAP_D];
    pu = pix[hvn_pkg::TAP_U];
    pc = pix[hvn_pkg::TAP_C];
    dx_neg = pl < pr;
    dz_neg = pd < pu;
    dx_mag = dx_neg ? pr - pl : pl - pr;
    dz_mag = dz_neg ? pu - pd : pd - pu;
    // |2p - 255| is always odd
    hc_mag = {pc[7] ? pc[6:0] : ~pc[6:0], 1'b1};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amag2 <= MAG_W'(dx_mag) * MAG_W'(max_height_q8);
      bmag2 <= MAG_W'(dz_mag) * MAG_W'(max_height_q8);
      nmag2 <= MAG_W'(hc_mag) * MAG_W'(max_height_q8);
      sa2   <= dx_neg;
      sb2   <= dz_neg;
      hneg2 <= !pc[7];
    end
  end

  // stage 3: squares, height reciprocal product
  logic [hvn_pkg::SQ_W-1:0] asq3, bsq3;
  logic [hvn_pkg::HP_W-1:0] hprod3;
  logic [MAG_W-1:0]         amag3, bmag3;
  logic                     sa3, sb3, hneg3;
  logic [hvn_pkg::Y_W-1:0]  hy;

  assign hy = hvn_pkg::Y_W'(nmag2) + hvn_pkg::HROUND;

  always_ff @(posedge clk) begin
    if (en) begin
      asq3   <= hvn_pkg::SQ_W'(amag2) * hvn_pkg::SQ_W'(amag2);
      bsq3   <= hvn_pkg::SQ_W'(bmag2) * hvn_pkg::SQ_W'(bmag2);
      hprod3 <= hvn_pkg::HP_W'(hy) * hvn_pkg::HP_W'(hvn_pkg::RECIP_255);
      amag3  <= amag2;
      bmag3  <= bmag2;
      sa3    <= sa2;
      sb3    <= sb2;
      hneg3  <= hneg2;
    end
  end

  // stage 4: sum of squares and signed height
  logic [hvn_pkg::SUM_W-1:0] ssum4;
  logic [HW-1:0]             hval4, hq3;
  logic [MAG_W-1:0]          amag4, bmag4;
  logic                      sa4, sb4;

  assign hq3 = hprod3[hvn_pkg::RECIP_SHIFT +: HW];

  always_ff @(posedge clk) begin
    if (en) begin
      ssum4 <= hvn_pkg::SUM_W'(asq3) + hvn_pkg::SUM_W'(bsq3) + hvn_pkg::C_SQ;
      hval4 <= hneg3 ? HW'(0) - hq3 : hq3;
      amag4 <= amag3;
      bmag4 <= bmag3;
      sa4   <= sa3;
      sb4   <= sb3;
    end
  end

  // square root of the length, scaled
  logic                  sq_vld;
  logic [RW-1:0]         root;
  logic [SQ_TAG_W-1:0]   sq_tag;
  logic [MAG_W-1:0]      amag_s, bmag_s;
  logic                  sa_s, sb_s;
  logic [HW-1:0]         hval_s;

  hvn_isqrt #(
    .ROOT_W (RW),
    .TAG_W  (SQ_TAG_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v4),
    .in_val   ({ssum4, {hvn_pkg::FRAC_SHIFT{1'b0}}}),
    .in_tag   ({sa4, amag4, sb4, bmag4, hval4}),
    .out_vld  (sq_vld),
    .out_root (root),
    .out_tag  (sq_tag)
  );

  assign {sa_s, amag_s, sb_s, bmag_s, hval_s} = sq_tag;

  // component division: (|v| * 2^22 + r) / (2r)
  logic [hvn_pkg::NUM_W-1:0] num_x, num_y, num_z;
  logic [hvn_pkg::DEN_W-1:0] den;

  assign den   = {root, 1'b0};
  assign num_x = (hvn_pkg::NUM_W'(amag_s) << hvn_pkg::DIV_SHIFT) + hvn_pkg::NUM_W'(root);
  assign num_y = (hvn_pkg::NUM_W'(hvn_pkg::C_VEC) << hvn_pkg::DIV_SHIFT)
                 + hvn_pkg::NUM_W'(root);
  assign num_z = (hvn_pkg::NUM_W'(bmag_s) << hvn_pkg::DIV_SHIFT) + hvn_pkg::NUM_W'(root);

  logic          vx, vy, vz, sx_d, sz_d;
  logic [QW-1:0] qx, qy, qz;
  logic [HW-1:0] hval_d;

  hvn_div #(
    .NUM_W (hvn_pkg::NUM_W), .DEN_W (hvn_pkg::DEN_W), .QUO_W (QW), .TAG_W (1)
  ) u_div_x (
    .clk (clk), .rst (rst), .en (en), .in_vld (sq_vld), .num (num_x), .den (den),
    .in_tag (sa_s), .out_vld (vx), .quo (qx), .out_tag (sx_d)
  );

  hvn_div #(
    .NUM_W (hvn_pkg::NUM_W), .DEN_W (hvn_pkg::DEN_W), .QUO_W (QW), .TAG_W (HW)
  ) u_div_y (
    .clk (clk), .rst (rst), .en (en), .in_vld (sq_vld), .num (num_y), .den (den),
    .in_tag (hval_s), .out_vld (vy), .quo (qy), .out_tag (hval_d)
  );

  hvn_div #(
    .NUM_W (hvn_pkg::NUM_W), .DEN_W (hvn_pkg::DEN_W), .QUO_W (QW), .TAG_W (1)
  ) u_div_z (
    .clk (clk), .rst (rst), .en (en), .in_vld (sq_vld), .num (num_z), .den (den),
    .in_tag (sb_s), .out_vld (vz), .quo (qz), .out_tag (sz_d)
  );

  assign v_last = vx && vy && vz;

  // saturation to q1.15
  function automatic logic [hvn_pkg::NRM_W-1:0] sat_comp(input logic [QW-1:0] q,
                                                         input logic neg);
    logic [QW-1:0] m;
    if (neg) begin
      m = (q > hvn_pkg::SAT_NEG) ? hvn_pkg::SAT_NEG : q;
      m = QW'(0) - m;
    end else begin
      m = (q > hvn_pkg::SAT_POS) ? hvn_pkg::SAT_POS : q;
    end
    return m[hvn_pkg::NRM_W-1:0];
  endfunction

  logic [QW-1:0] qy_sat;

  assign qy_sat = (qy > hvn_pkg::SAT_POS) ? hvn_pkg::SAT_POS : qy;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_block) begin
      out_valid <= v_last;
    end
  end

  always_ff @(posedge clk) begin
    if (v_last && !out_block) begin
      vertex_height <= hval_d;
      normal_x      <= sat_comp(qx, sx_d);
      normal_y      <= qy_sat[hvn_pkg::NRMY_W-1:0];
      normal_z      <= sat_comp(qz, sz_d);
    end
  end

endmodule

// ===== hw/rtl/hvn_checker.sv =====
// port level checks for the heightmap vertex normal block, bound to the top level
module hvn_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [hvn_pkg::HEIGHT_W-1:0] vertex_height,
  input logic signed [hvn_pkg::NRM_W-1:0]    normal_x,
  input logic [hvn_pkg::NRMY_W-1:0]          normal_y,
  input logic signed [hvn_pkg::NRM_W-1:0]    normal_z
);

  // input back-pressure only comes from a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a blocked result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented straight after reset");

  // the up component never vanishes, even at the steepest slope
  a_up_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (normal_y != '0))
    else $error("normal_y is zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(vertex_height) &&
      $stable(normal_x) && $stable(normal_y) && $stable(normal_z)))
    else $error("stalled result changed");

endmodule

bind heightmap_vertex_normal hvn_checker u_hvn_checker (.*);
